### src/rar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg
// Shared constants for the rational arithmetic reduction core: default
// operand width, operation codes and result status codes.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int WIDTH_DEF = 32;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Result status codes carried in the output tuser.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

endpackage

### src/rational_arith_reduce_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_reduce_core
// Exact add, subtract, multiply or divide of two fractions, reduced to
// lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// Each input transfer carries two fractions and an operation code; each one
// produces exactly one output transfer with the reduced result and a status.
// The core handles one request at a time and drops in_tready while it works.
// A request that fails the zero-denominator or divide-by-zero check skips
// the datapath and goes to the range check and hand-off. Otherwise the work
// runs on a shared datapath: up to three products through one WIDTH x WIDTH
// multiplier; a binary GCD that does one shift or one subtract per cycle on
// 2*WIDTH-bit magnitudes; and two restoring divisions, one quotient bit per
// cycle, that divide numerator and denominator by the GCD.
// A finished result sits in an output register, so the next request is
// accepted while the previous result still waits.
// Only the low WIDTH bits of each operand are used, sign-extended.
// ----------------------------------------------------------------------------
module rational_arith_reduce_core
  import rar_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Request channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata fields, lowest bit up: a_num[31:0], a_den[63:32],
  // b_num[95:64], b_den[127:96].
  input  logic [127:0] in_tdata,
  // in_tuser fields: req_type[1:0].
  input  logic [1:0]   in_tuser,
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata fields, lowest bit up: res_num[31:0], res_den[62:32],
  // zero fill [63].
  output logic [63:0]  out_tdata,
  // out_tuser fields: status[1:0].
  output logic [1:0]   out_tuser
);

  localparam int MW = 2 * WIDTH;          // exact width of the intermediates
  localparam int CW = $clog2(MW);         // divide step counter width

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL0 = 4'd1;   // first numerator product
  localparam logic [3:0] S_MUL1 = 4'd2;   // second numerator product
  localparam logic [3:0] S_MUL2 = 4'd3;   // denominator product
  localparam logic [3:0] S_ADD  = 4'd4;   // signed combine of the products
  localparam logic [3:0] S_TWOS = 4'd5;   // strip common factors of two
  localparam logic [3:0] S_ODD  = 4'd6;   // binary GCD on odd parts
  localparam logic [3:0] S_DIVN = 4'd7;   // numerator / gcd
  localparam logic [3:0] S_DIVD = 4'd8;   // denominator / gcd
  localparam logic [3:0] S_EMIT = 4'd9;   // range check and hand-off

  logic [3:0] state_r, state_nxt;

  // Captured request.
  logic [1:0]       op_r, op_nxt;
  logic [WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic [WIDTH-1:0] an_nxt, ad_nxt, bn_nxt, bd_nxt;
  logic             an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic             an_s_nxt, ad_s_nxt, bn_s_nxt, bd_s_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             neg_r, neg_nxt;

  // Datapath registers.
  logic [MW-1:0] p0_r, p0_nxt;     // first numerator product
  logic [MW-1:0] p1_r, p1_nxt;     // second numerator product
  logic [MW-1:0] x_r, x_nxt;       // GCD operand, ends as the gcd
  logic [MW-1:0] y_r, y_nxt;       // GCD operand
  logic [MW-1:0] ns_r, ns_nxt;     // numerator, later reduced numerator
  logic [MW-1:0] ds_r, ds_nxt;     // denominator, later reduced denominator
  logic [MW-1:0] acc_r, acc_nxt;   // dividend shifting out, quotient in
  logic [MW-1:0] rem_r, rem_nxt;   // partial remainder
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_num_r, out_num_nxt;
  logic [30:0] out_den_r, out_den_nxt;
  logic [1:0]  out_st_r, out_st_nxt;

  // Operand fields, sign-extended from bit WIDTH-1 and split into sign and
  // magnitude. The magnitude of the most negative value still fits WIDTH bits.
  logic [WIDTH-1:0] f_an, f_ad, f_bn, f_bd;
  logic [WIDTH-1:0] m_an, m_ad, m_bn, m_bd;

  assign f_an = in_tdata[WIDTH-1:0];
  assign f_ad = in_tdata[32+WIDTH-1:32];
  assign f_bn = in_tdata[64+WIDTH-1:64];
  assign f_bd = in_tdata[96+WIDTH-1:96];
  assign m_an = f_an[WIDTH-1] ? (~f_an + 1'b1) : f_an;
  assign m_ad = f_ad[WIDTH-1] ? (~f_ad + 1'b1) : f_ad;
  assign m_bn = f_bn[WIDTH-1] ? (~f_bn + 1'b1) : f_bn;
  assign m_bd = f_bd[WIDTH-1] ? (~f_bd + 1'b1) : f_bd;

  // The one multiplier, its operands chosen by the sequencer.
  logic [WIDTH-1:0] mul_a, mul_b;
  logic [MW-1:0]    mul_p;

  always_comb begin
    mul_a = ad_r;
    mul_b = bd_r;
    case (state_r)
      S_MUL0: begin
        mul_a = an_r;
        mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      S_MUL1: begin
        mul_a = ad_r;
        mul_b = bn_r;
      end
      S_MUL2: begin
        mul_a = ad_r;
        mul_b = (op_r == OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
  end

  assign mul_p = MW'(mul_a) * MW'(mul_b);

  // Signs of the two numerator terms and of the denominator.
  logic s0, s1, den_neg;
  assign s0      = an_s_r ^ ((op_r == OP_MUL) ? bn_s_r : bd_s_r);
  assign s1      = ad_s_r ^ bn_s_r ^ (op_r == OP_SUB);
  assign den_neg = ad_s_r ^ ((op_r == OP_DIV) ? bn_s_r : bd_s_r);

  // Shared subtractors: the signed combine in S_ADD and the GCD step in
  // S_ODD both need a - b with its borrow and b - a.
  logic [MW-1:0] sub_a, sub_b;
  logic [MW:0]   sub_ab;
  logic [MW-1:0] sub_ba;

  assign sub_a  = (state_r == S_ODD) ? x_r : p0_r;
  assign sub_b  = (state_r == S_ODD) ? y_r : p1_r;
  assign sub_ab = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ba = sub_b - sub_a;

  // Numerator magnitude and sign after the combine.
  logic [MW-1:0] num_mag;
  logic          num_neg;

  always_comb begin
    num_mag = p0_r;
    num_neg = s0;
    if ((op_r == OP_ADD) || (op_r == OP_SUB)) begin
      if (s0 == s1) begin
        num_mag = p0_r + p1_r;
        num_neg = s0;
      end else if (!sub_ab[MW]) begin
        num_mag = sub_ab[MW-1:0];
        num_neg = s0;
      end else begin
        num_mag = sub_ba;
        num_neg = s1;
      end
    end
  end

  // Restoring divide step; the divisor is the gcd held in x_r.
  logic [MW:0]   div_t, div_diff;
  logic          div_take;
  logic [MW-1:0] div_rem, div_q;

  assign div_t    = {rem_r, acc_r[MW-1]};
  assign div_diff = div_t - {1'b0, x_r};
  assign div_take = !div_diff[MW];
  assign div_rem  = div_take ? div_diff[MW-1:0] : div_t[MW-1:0];
  assign div_q    = {acc_r[MW-2:0], div_take};

  // Final range check and two's complement numerator.
  logic                    res_neg, n_ovf, d_ovf;
  logic [1:0]              fin_st;
  logic signed [WIDTH-1:0] num_w;

  assign res_neg = neg_r && (ns_r != '0);
  assign d_ovf   = |ds_r[MW-1:WIDTH-1];
  assign n_ovf   = res_neg ? ((|ns_r[MW-1:WIDTH]) || (ns_r[WIDTH-1] && (|ns_r[WIDTH-2:0])))
                           : (|ns_r[MW-1:WIDTH-1]);
  assign fin_st  = (status_r != ST_OK) ? status_r : ((d_ovf || n_ovf) ? ST_OVF : ST_OK);
  assign num_w   = res_neg ? signed'(~ns_r[WIDTH-1:0] + 1'b1) : signed'(ns_r[WIDTH-1:0]);

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    bn_nxt        = bn_r;
    bd_nxt        = bd_r;
    an_s_nxt      = an_s_r;
    ad_s_nxt      = ad_s_r;
    bn_s_nxt      = bn_s_r;
    bd_s_nxt      = bd_s_r;
    status_nxt    = status_r;
    neg_nxt       = neg_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    ns_nxt        = ns_r;
    ds_nxt        = ds_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_num_nxt   = out_num_r;
    out_den_nxt   = out_den_r;
    out_st_nxt    = out_st_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_tuser;
          an_nxt   = m_an;
          ad_nxt   = m_ad;
          bn_nxt   = m_bn;
          bd_nxt   = m_bd;
          an_s_nxt = f_an[WIDTH-1];
          ad_s_nxt = f_ad[WIDTH-1];
          bn_s_nxt = f_bn[WIDTH-1];
          bd_s_nxt = f_bd[WIDTH-1];
          // A zero denominator wins over a zero divisor.
          if ((f_ad == '0) || (f_bd == '0)) begin
            status_nxt = ST_ZDEN;
            state_nxt  = S_EMIT;
          end else if ((in_tuser == OP_DIV) && (f_bn == '0)) begin
            status_nxt = ST_DIVZ;
            state_nxt  = S_EMIT;
          end else begin
            status_nxt = ST_OK;
            state_nxt  = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        p0_nxt    = mul_p;
        state_nxt = ((op_r == OP_ADD) || (op_r == OP_SUB)) ? S_MUL1 : S_MUL2;
      end
      S_MUL1: begin
        p1_nxt    = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        y_nxt     = mul_p;
        ds_nxt    = mul_p;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        neg_nxt = num_neg ^ den_neg;
        x_nxt   = num_mag;
        ns_nxt  = num_mag;
        if (num_mag == '0) begin
          // Zero reduces straight to 0/1.
          ds_nxt    = MW'(1);
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_TWOS;
        end
      end
      S_TWOS: begin
        // Dividing out common powers of two from both the GCD operands and
        // the values to be reduced leaves the odd part of the gcd to find.
        if (!x_r[0] && !y_r[0]) begin
          x_nxt  = x_r >> 1;
          y_nxt  = y_r >> 1;
          ns_nxt = ns_r >> 1;
          ds_nxt = ds_r >> 1;
        end else begin
          state_nxt = S_ODD;
        end
      end
      S_ODD: begin
        if (y_r == '0) begin
          acc_nxt   = ns_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (!sub_ab[MW] && (sub_ab[MW-1:0] != '0)) begin
          x_nxt = sub_ab[MW-1:0];
        end else begin
          y_nxt = sub_ba;
        end
      end
      S_DIVN: begin
        acc_nxt = div_q;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(MW - 1)) begin
          ns_nxt    = div_q;
          acc_nxt   = ds_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        acc_nxt = div_q;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(MW - 1)) begin
          ds_nxt    = div_q;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = fin_st;
          if (fin_st == ST_OK) begin
            out_num_nxt = 32'(num_w);
            out_den_nxt = 31'(ds_r[WIDTH-2:0]);
          end else begin
            out_num_nxt = '0;
            out_den_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
    bn_r      <= bn_nxt;
    bd_r      <= bd_nxt;
    an_s_r    <= an_s_nxt;
    ad_s_r    <= ad_s_nxt;
    bn_s_r    <= bn_s_nxt;
    bd_s_r    <= bd_s_nxt;
    status_r  <= status_nxt;
    neg_r     <= neg_nxt;
    p0_r      <= p0_nxt;
    p1_r      <= p1_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    ns_r      <= ns_nxt;
    ds_r      <= ds_nxt;
    acc_r     <= acc_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_den_r, out_num_r};
  assign out_tuser  = out_st_r;

endmodule

### sim/tb_rational_arith_reduce_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arith_reduce_core
// Self-checking bench for the rational add/subtract/multiply/divide core.
// A short table of hand-picked requests covers the corner cases. A long run
// of random requests follows. Every result transfer is compared field by
// field against a behavioral reduction of the same fraction pair, or, for
// most table rows, against a result written out by hand.
// ----------------------------------------------------------------------------
module tb_rational_arith_reduce_core;
  import rar_pkg::*;

  // Run shape. The idle watchdog must tolerate the long output hold-off
  // plus one full request, with a wide margin.
  localparam int RAND_ITEMS   = 1830;
  localparam int IDLE_LIMIT   = 6000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 800;
  localparam int PAUSE_AT     = 900;

  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MINUS_1  = 32'hFFFF_FFFF;

  // One reduced fraction as it appears on the result channel.
  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  st;
  } frac_result_t;

  // One request. When known is set, res holds a hand-written answer that
  // is used instead of the computed one.
  typedef struct packed {
    logic [1:0]   op;
    logic [31:0]  a_num;
    logic [31:0]  a_den;
    logic [31:0]  b_num;
    logic [31:0]  b_den;
    logic         known;
    frac_result_t res;
  } frac_req_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  logic [1:0]   in_tuser;   // req_type[1:0]
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // res_num[31:0], res_den[62:32], zero fill [63]
  logic [1:0]   out_tuser;  // status[1:0]

  frac_result_t pending_results[$];
  frac_req_t    directed_reqs[$];
  int           mismatches;
  int           idle_cycles;

  rational_arith_reduce_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Splits a 32-bit two's complement operand into sign and magnitude. The
  // magnitude of the most negative value is 2^31, which still fits 32 bits
  // unsigned; 64 bits keep every later product exact.
  function automatic void split_operand(input logic [31:0] w, output logic neg,
                                        output logic [63:0] mag);
    neg = w[31];
    mag = w[31] ? (64'h1_0000_0000 - {32'd0, w}) : {32'd0, w};
  endfunction

  // Computes the reduced result of one request. The raw numerator and
  // denominator are formed in sign-magnitude form, both are divided by
  // their GCD (Euclid's remainder loop), and the sign moves to the
  // numerator. Anything that does not fit 32-bit signed is an overflow.
  function automatic frac_result_t reduce_fraction_op(input logic [1:0] op,
                                                      input logic [31:0] an,
                                                      input logic [31:0] ad,
                                                      input logic [31:0] bn,
                                                      input logic [31:0] bd);
    logic         an_s, ad_s, bn_s, bd_s, p_s, q_s, num_s, den_s, neg;
    logic [63:0]  an_m, ad_m, bn_m, bd_m, p_m, q_m, num_m, den_m;
    logic [63:0]  x, y, n, d;
    frac_result_t r;
    r = '0;
    split_operand(an, an_s, an_m);
    split_operand(ad, ad_s, ad_m);
    split_operand(bn, bn_s, bn_m);
    split_operand(bd, bd_s, bd_m);
    // A zero denominator outranks a zero divisor.
    if (ad_m == 64'd0 || bd_m == 64'd0) begin
      r.st = ST_ZDEN;
      return r;
    end
    if (op == OP_DIV && bn_m == 64'd0) begin
      r.st = ST_DIVZ;
      return r;
    end
    case (op)
      OP_ADD, OP_SUB: begin
        p_m   = an_m * bd_m;
        p_s   = an_s ^ bd_s;
        q_m   = ad_m * bn_m;
        q_s   = ad_s ^ bn_s ^ (op == OP_SUB);
        den_m = ad_m * bd_m;
        den_s = ad_s ^ bd_s;
        // The sign attached to a zero term never changes the outcome.
        if (p_s == q_s) begin
          num_m = p_m + q_m;
          num_s = p_s;
        end else if (p_m >= q_m) begin
          num_m = p_m - q_m;
          num_s = p_s;
        end else begin
          num_m = q_m - p_m;
          num_s = q_s;
        end
      end
      OP_MUL: begin
        num_m = an_m * bn_m;
        num_s = an_s ^ bn_s;
        den_m = ad_m * bd_m;
        den_s = ad_s ^ bd_s;
      end
      default: begin
        num_m = an_m * bd_m;
        num_s = an_s ^ bd_s;
        den_m = ad_m * bn_m;
        den_s = ad_s ^ bn_s;
      end
    endcase
    x = num_m;
    y = den_m;
    while (x != 64'd0 && y != 64'd0) begin
      if (x >= y) x = x % y;
      else y = y % x;
    end
    // The denominator is nonzero here, so the GCD is at least one, and a
    // zero numerator reduces to 0/1.
    n   = num_m / (x + y);
    d   = den_m / (x + y);
    neg = (n != 64'd0) && (num_s != den_s);
    if (d > 64'h7FFF_FFFF || (neg ? (n > 64'h8000_0000) : (n > 64'h7FFF_FFFF))) begin
      r.st = ST_OVF;
      return r;
    end
    x     = neg ? (64'd0 - n) : n;
    r.num = x[31:0];
    r.den = d[30:0];
    r.st  = ST_OK;
    return r;
  endfunction

  function automatic frac_req_t make_req(input logic known, input logic [1:0] op,
                                         input logic [31:0] an, input logic [31:0] ad,
                                         input logic [31:0] bn, input logic [31:0] bd,
                                         input logic [31:0] num, input logic [30:0] den,
                                         input logic [1:0] st);
    frac_req_t rq;
    rq.op        = op;
    rq.a_num     = an;
    rq.a_den     = ad;
    rq.b_num     = bn;
    rq.b_den     = bd;
    rq.known     = known;
    rq.res.num   = num;
    rq.res.den   = den;
    rq.res.st    = st;
    return rq;
  endfunction

  // Random operand with a bias: small values give frequent common factors
  // and in-range results, wide values reach every bit and the overflow
  // path, and zero and the extremes show up regularly.
  function automatic logic [31:0] rand_operand();
    logic [31:0] r;
    int unsigned pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: r = 32'd0;
      1: begin
        case ($urandom_range(0, 3))
          0:       r = MOST_NEG;
          1:       r = MOST_POS;
          2:       r = MINUS_1;
          default: r = 32'd1;
        endcase
      end
      2, 3, 4, 5, 6, 7: r = $urandom_range(0, 200) - 100;
      8, 9, 10, 11: begin
        r = $urandom;
        r = {{16{r[15]}}, r[15:0]};
      end
      default: r = $urandom;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Presents one request and holds it until the core takes it. The
  // expected result is queued at the accepting edge.
  task automatic offer_request(input frac_req_t rq);
    in_tvalid <= 1'b1;
    in_tdata  <= {rq.b_den, rq.b_num, rq.a_den, rq.a_num};
    in_tuser  <= rq.op;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (rq.known) pending_results.push_back(rq.res);
    else pending_results.push_back(reduce_fraction_op(rq.op, rq.a_num, rq.a_den,
                                                      rq.b_num, rq.b_den));
  endtask

  // Idle time between request transfers. Every fourth window of 150
  // requests is sent back to back. At one point the sender waits until
  // the core has delivered every outstanding result.
  task automatic sender_gap(input int idx);
    int gap;
    gap = (((idx / 150) % 4) == 3) ? 0 : $urandom_range(0, 5);
    if (idx == PAUSE_AT) begin
      in_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end else if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Request side: reset, the directed table, then random requests.
  initial begin : request_source
    frac_req_t rq;
    int        idx;
    int        total;
    mismatches = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_ADD;

    // Hand-written answers appear only where they are obvious; the other
    // rows are checked against the computed reduction.
    directed_reqs.push_back(make_req(1, OP_ADD, 1, 2, 1, 3, 5, 6, ST_OK));
    directed_reqs.push_back(make_req(1, OP_ADD, 1, 0, 1, 1, 0, 0, ST_ZDEN));
    directed_reqs.push_back(make_req(1, OP_MUL, 1, 1, 1, 0, 0, 0, ST_ZDEN));
    // Zero denominator together with a zero divisor: the denominator wins.
    directed_reqs.push_back(make_req(1, OP_DIV, 1, 0, 0, 1, 0, 0, ST_ZDEN));
    directed_reqs.push_back(make_req(1, OP_DIV, 1, 2, 0, 5, 0, 0, ST_DIVZ));
    // Zero results come out as 0/1.
    directed_reqs.push_back(make_req(1, OP_SUB, 1, 2, 1, 2, 0, 1, ST_OK));
    directed_reqs.push_back(make_req(1, OP_MUL, 0, -32'sd7, 3, 4, 0, 1, ST_OK));
    directed_reqs.push_back(make_req(1, OP_SUB, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS,
                                     0, 1, ST_OK));
    // A negative denominator moves its sign to the numerator.
    directed_reqs.push_back(make_req(1, OP_ADD, 1, -32'sd2, 0, 1, MINUS_1, 2, ST_OK));
    directed_reqs.push_back(make_req(1, OP_DIV, 3, 4, -32'sd3, 8, -32'sd2, 1, ST_OK));
    directed_reqs.push_back(make_req(1, OP_DIV, MINUS_1, MINUS_1, MINUS_1, MINUS_1,
                                     1, 1, ST_OK));
    // Range limits: -2^31 fits as a numerator but not as a denominator,
    // and +2^31 overflows.
    directed_reqs.push_back(make_req(1, OP_ADD, MOST_NEG, 1, 0, 1, MOST_NEG, 1, ST_OK));
    directed_reqs.push_back(make_req(1, OP_ADD, 1, MOST_NEG, 0, 1, 0, 0, ST_OVF));
    directed_reqs.push_back(make_req(1, OP_MUL, MOST_NEG, 1, MINUS_1, 1, 0, 0, ST_OVF));
    directed_reqs.push_back(make_req(1, OP_MUL, MOST_POS, 1, MOST_POS, 1, 0, 0, ST_OVF));
    directed_reqs.push_back(make_req(1, OP_ADD, MOST_POS, 1, 1, 1, 0, 0, ST_OVF));
    directed_reqs.push_back(make_req(1, OP_SUB, MOST_NEG, 1, 1, 1, 0, 0, ST_OVF));
    directed_reqs.push_back(make_req(1, OP_DIV, MOST_POS, 1, MOST_POS, 1, 1, 1, ST_OK));
    // Wide operands whose answers need the full reduction.
    directed_reqs.push_back(make_req(0, OP_ADD, 1, MOST_POS, 1, MOST_POS, 0, 0, ST_OK));
    directed_reqs.push_back(make_req(0, OP_ADD, 32'hDEAD_BEEF, 32'h1234_5678,
                                     32'h0765_4321, 32'hFFFF_FFF1, 0, 0, ST_OK));
    directed_reqs.push_back(make_req(0, OP_SUB, 32'h0001_0000, 32'h0000_6000,
                                     32'hFFFF_8000, 32'h0000_0C00, 0, 0, ST_OK));
    directed_reqs.push_back(make_req(0, OP_MUL, 32'h8000_0001, 32'h0000_0003,
                                     32'h0000_0006, MOST_NEG, 0, 0, ST_OK));
    directed_reqs.push_back(make_req(0, OP_DIV, 32'h0F0F_0F0F, 32'h7777_7777,
                                     32'hAAAA_AAAA, 32'h5555_5555, 0, 0, ST_OK));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    total = directed_reqs.size() + RAND_ITEMS;
    for (idx = 0; idx < total; idx++) begin
      if (idx < directed_reqs.size()) begin
        rq = directed_reqs[idx];
      end else begin
        rq = make_req(0, 2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                      rand_operand(), rand_operand(), 0, 0, ST_OK);
      end
      offer_request(rq);
      if (idx == total - 1) in_tvalid <= 1'b0;
      else sender_gap(idx);
    end

    // Let the core finish and stay quiet for a while in case it emits
    // anything extra; the watchdog bounds the wait.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Compares the result on the output bus with the oldest expectation.
  task automatic check_result();
    frac_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result", {out_tuser, out_tdata[61:0]}, 64'd0);
      return;
    end
    want = pending_results.pop_front();
    if (out_tdata[31:0] !== want.num)
      report_mismatch("res_num", 64'(out_tdata[31:0]), 64'(want.num));
    if (out_tdata[62:32] !== want.den)
      report_mismatch("res_den", 64'(out_tdata[62:32]), 64'(want.den));
    if (out_tuser !== want.st)
      report_mismatch("status", 64'(out_tuser), 64'(want.st));
  endtask

  // Result side. The ready gap is redrawn for every result, with windows
  // of no stalling and one long hold-off that lets the core fill its
  // output register and then back-pressure the request channel.
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      else if (((taken / 120) % 4) == 2) gap = 0;
      else gap = $urandom_range(0, 5);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      check_result();
      taken++;
    end
  end

  // Watchdog: a run of cycles with no transfer on either channel means
  // the core has hung or lost a result.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
